[sv/rvd_pkg.sv]
// ----------------------------------------------------------------------------
// rvd_pkg
// Shared types, codes and constants of the RTP video depacketizer.
// ----------------------------------------------------------------------------
`default_nettype none

package rvd_pkg;

    localparam int MAX_LINE_HEADERS_DEF = 8;
    localparam int MAX_PACKET_BYTES_DEF = 2047;

    localparam int RTP_HDR_LEN  = 12;
    localparam int LINES_AT     = 14;
    localparam int LHDR_BYTES   = 6;

    localparam logic [27:0] FRAME_CAP = 28'h8000000;

    // configuration register indexes
    localparam logic [1:0] CFG_EXTRACT = 2'd0;
    localparam logic [1:0] CFG_WIDTH   = 2'd1;
    localparam logic [1:0] CFG_HEIGHT  = 2'd2;
    localparam logic [1:0] CFG_PIXEL   = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_FILL   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // packet error codes
    localparam logic [2:0] ERR_OK       = 3'd0;
    localparam logic [2:0] ERR_SHORT    = 3'd1;
    localparam logic [2:0] ERR_HDR_SCAN = 3'd2;
    localparam logic [2:0] ERR_PAYLOAD  = 3'd3;
    localparam logic [2:0] ERR_ALIGN    = 3'd4;
    localparam logic [2:0] ERR_OFFSET   = 3'd5;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR,
        PH_EXT,
        PH_LHDR,
        PH_DATA,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_LINE_RD,
        SQ_LINE_MUL1,
        SQ_LINE_MUL2,
        SQ_LINE_EVAL,
        SQ_STATUS,
        SQ_FLUSH
    } t_seq;

    // decoded line header as kept in the header memory
    typedef struct packed {
        logic [15:0] length;
        logic [14:0] row;
        logic [14:0] offset;
        logic        cont;
    } t_lhdr;

    typedef struct packed {
        logic        first_packet;
        logic [6:0]  payload_type;
        logic        marker_missing;
        logic        timestamp_wrapped;
        logic [31:0] received_total;
        logic [31:0] dropped_total;
        logic [2:0]  packet_error;
        logic        new_frame;
        logic [27:0] fill_length;
        logic [7:0]  data_byte;
        logic [1:0]  kind;
    } t_result;

endpackage

`default_nettype wire

[sv/rvd_lhdr_ram.sv]
// ----------------------------------------------------------------------------
// rvd_lhdr_ram
// Line header memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rvd_lhdr_ram
    import rvd_pkg::*;
#(
    parameter int DEPTH = MAX_LINE_HEADERS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_lhdr         i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_lhdr              o_rd_data
);

    t_lhdr r_mem [DEPTH];
    t_lhdr r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[sv/rvd_geom.sv]
// ----------------------------------------------------------------------------
// rvd_geom
// Frame geometry: registered frame size and two-stage line offset product.
// ----------------------------------------------------------------------------
`default_nettype none

module rvd_geom
    import rvd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic [12:0] i_frame_width,
    input  wire logic [12:0] i_frame_height,
    input  wire logic [3:0]  i_pixel_bytes,
    input  wire logic [14:0] i_row,
    input  wire logic [14:0] i_offset,
    output logic [27:0]      o_frame_size,
    output logic [32:0]      o_frame_offset
);

    logic [25:0] r_wh;
    logic [27:0] r_fs;
    logic [28:0] r_ro;
    logic [32:0] r_fo;
    logic [29:0] fs_full;

    assign fs_full = 30'(r_wh) * 30'(i_pixel_bytes);

    always_ff @(posedge i_clk) begin
        r_wh <= 26'(i_frame_width) * 26'(i_frame_height);
        r_fs <= (fs_full > 30'(FRAME_CAP)) ? FRAME_CAP : fs_full[27:0];
        r_ro <= 29'(i_row) * 29'(i_frame_width) + 29'(i_offset);
        r_fo <= 33'(r_ro) * 33'(i_pixel_bytes);
    end

    assign o_frame_size   = r_fs;
    assign o_frame_offset = r_fo;

endmodule

`default_nettype wire

[sv/rtp_video_depacketizer.sv]
// ----------------------------------------------------------------------------
// rtp_video_depacketizer
// RTP receive monitor with RFC 4175 uncompressed video depacketizing.
// ----------------------------------------------------------------------------
// Flow: a byte's first result passes the held-result register, then the
//   output register; the input is not ready again until the byte is done.
// Each line header walked at a line end adds a memory read plus two
//   multiplier stages before its evaluation, and status adds its own step.
// Reset: i_rst_n synchronous, active low; counters and flags clear, the
//   block waits for the first frame edge; header memory is not cleared.
`default_nettype none

module rtp_video_depacketizer
    import rvd_pkg::*;
#(
    parameter int MAX_LINE_HEADERS = MAX_LINE_HEADERS_DEF,
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // slave: tdata = pkt_byte[7:0], packet_length[18:8]; tuser = first_byte
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [23:0]  i_s_tdata,
    input  wire logic         i_s_tuser,
    input  wire logic         i_s_tlast,
    // master: tdata = data_byte, fill_length, new_frame, packet_error,
    // dropped_total, received_total, timestamp_wrapped, marker_missing,
    // payload_type, first_packet, zero pad; tuser = kind
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [119:0]      o_m_tdata,
    output logic [1:0]        o_m_tuser,
    output logic              o_m_tlast,
    // configuration write
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [12:0]  i_cfg_data
);

    localparam int LW = $clog2(MAX_PACKET_BYTES + 1);
    localparam int CW = $clog2(MAX_LINE_HEADERS + 1);
    localparam int AW = (MAX_LINE_HEADERS > 1) ? $clog2(MAX_LINE_HEADERS) : 1;

    // configuration
    logic        r_en;
    logic [12:0] r_fw, r_fh;
    logic [3:0]  r_pb;

    // control and packet state
    t_seq          r_state, n_state;
    t_phase        r_phase, n_phase;
    logic [15:0]   r_prev_seq, n_prev_seq;
    logic [31:0]   r_prev_ts, n_prev_ts;
    logic          r_prev_mark, n_prev_mark;
    logic          r_type_seen, n_type_seen;
    logic [31:0]   r_drop, n_drop;
    logic [31:0]   r_pcnt, n_pcnt;
    logic [31:0]   r_frame_ts, n_frame_ts;
    logic          r_await, n_await;
    logic [27:0]   r_wpos, n_wpos;
    logic [LW-1:0] r_bidx, n_bidx;
    logic [LW-1:0] r_plen, n_plen;
    logic [LW-1:0] r_next, n_next;
    logic [47:0]   r_hshift, n_hshift;
    logic [CW-1:0] r_hcnt, n_hcnt;
    logic [CW-1:0] r_cursor, n_cursor;
    logic [15:0]   r_lrem, n_lrem;
    logic [2:0]    r_sub, n_sub;
    logic [2:0]    r_err, n_err;
    logic [7:0]    r_mtype, n_mtype;
    logic          r_hdone, n_hdone;
    logic          r_wrap, n_wrap;
    logic          r_miss, n_miss;
    logic          r_first, n_first;
    logic          r_fpend, n_fpend;
    logic          r_lastb, n_lastb;

    // result staging: one held result, then the output register
    t_result r_pend, n_pend;
    logic    r_pv, n_pv;
    t_result r_out;
    logic    r_ov;
    logic    push, flush;

    // memory and geometry
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr;
    t_lhdr         wr_data, rd_data;
    logic [27:0]   fs;
    logic [32:0]   fo;

    logic          s_acc, can_emit, blocked;
    logic [7:0]    in_byte;
    logic [10:0]   in_len;

    assign s_acc    = i_s_tvalid && o_s_tready;
    assign can_emit = !r_ov || i_m_tready;
    assign blocked  = r_pv && !can_emit;
    assign in_byte  = i_s_tdata[7:0];
    assign in_len   = i_s_tdata[18:8];

    assign o_s_tready  = (r_state == SQ_IDLE);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= 1'b0;
            r_fw <= 13'd1920;
            r_fh <= 13'd1080;
            r_pb <= 4'd2;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_EXTRACT: r_en <= i_cfg_data[0];
                CFG_WIDTH:   r_fw <= i_cfg_data;
                CFG_HEIGHT:  r_fh <= i_cfg_data;
                CFG_PIXEL:   r_pb <= i_cfg_data[3:0];
                default:     r_en <= r_en;
            endcase
        end
    end

    rvd_lhdr_ram #(
        .DEPTH (MAX_LINE_HEADERS),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_cursor[AW-1:0]),
        .o_rd_data (rd_data)
    );

    rvd_geom u_geom (
        .i_clk          (i_clk),
        .i_frame_width  (r_fw),
        .i_frame_height (r_fh),
        .i_pixel_bytes  (r_pb),
        .i_row          (rd_data.row),
        .i_offset       (rd_data.offset),
        .o_frame_size   (fs),
        .o_frame_offset (fo)
    );

    always_comb begin
        logic [15:0] seq;
        logic [31:0] ts;
        logic [15:0] diff;
        logic [47:0] s;
        logic [15:0] rem;
        logic [15:0] lenc;
        logic        go_lines;
        logic        fill_need;
        t_result     g;

        n_state = r_state;   n_phase = r_phase;
        n_prev_seq = r_prev_seq; n_prev_ts = r_prev_ts; n_prev_mark = r_prev_mark;
        n_type_seen = r_type_seen; n_drop = r_drop; n_pcnt = r_pcnt;
        n_frame_ts = r_frame_ts; n_await = r_await; n_wpos = r_wpos;
        n_bidx = r_bidx; n_plen = r_plen; n_next = r_next; n_hshift = r_hshift;
        n_hcnt = r_hcnt; n_cursor = r_cursor; n_lrem = r_lrem; n_sub = r_sub;
        n_err = r_err; n_mtype = r_mtype; n_hdone = r_hdone; n_wrap = r_wrap;
        n_miss = r_miss; n_first = r_first; n_fpend = r_fpend; n_lastb = r_lastb;
        n_pend = r_pend; n_pv = r_pv;
        push = 1'b0; flush = 1'b0;
        wr_en = 1'b0; wr_addr = r_hcnt[AW-1:0]; wr_data = '0; rd_en = 1'b0;
        seq = '0; ts = '0; diff = '0; s = '0; rem = '0; lenc = '0;
        go_lines = 1'b0; fill_need = 1'b0; g = '0;

        case (r_state)
            SQ_IDLE: begin
                if (s_acc) begin
                    n_lastb = i_s_tlast;
                    if (i_s_tuser) begin
                        n_phase = PH_HDR;
                        n_bidx = '0;
                        n_plen = (32'(in_len) > 32'(MAX_PACKET_BYTES)) ?
                                 LW'(MAX_PACKET_BYTES) : LW'(in_len);
                        n_err = ERR_OK; n_mtype = '0; n_hdone = 1'b0;
                        n_wrap = 1'b0; n_miss = 1'b0; n_first = 1'b0;
                        n_hshift = '0; n_hcnt = '0; n_cursor = '0; n_lrem = '0;
                    end
                    if (n_phase != PH_IDLE) begin
                        if (32'(n_plen) >= 32'(RTP_HDR_LEN) && n_bidx < n_plen) begin
                            case (n_phase)
                                PH_HDR: begin
                                    if (32'(n_bidx) == 32'd1) begin
                                        n_mtype = in_byte;
                                    end else if (32'(n_bidx) >= 32'd2 &&
                                                 32'(n_bidx) <= 32'd7) begin
                                        n_hshift = {n_hshift[39:0], in_byte};
                                    end else if (32'(n_bidx) == 32'(RTP_HDR_LEN - 1)) begin
                                        seq  = n_hshift[47:32];
                                        ts   = n_hshift[31:0];
                                        diff = seq - r_prev_seq - 16'd1;
                                        n_hdone = 1'b1;
                                        if (r_prev_seq != '0 && diff != '0) begin
                                            n_drop = r_drop + 32'(diff);
                                        end
                                        n_prev_seq = (seq == 16'hFFFF) ? 16'd0 : seq;
                                        if (r_prev_ts != '0) begin
                                            n_wrap = ts < r_prev_ts;
                                            n_miss = (ts != r_prev_ts) && !r_prev_mark;
                                        end
                                        n_prev_ts   = ts;
                                        n_prev_mark = n_mtype[7];
                                        n_first     = !r_type_seen;
                                        n_type_seen = 1'b1;
                                        n_pcnt      = r_pcnt + 32'd1;
                                        if (r_en) begin
                                            if (r_frame_ts != '0 && r_frame_ts != ts) begin
                                                if (r_await) begin
                                                    n_await = 1'b0;
                                                end else begin
                                                    // close the old frame
                                                    if (r_wpos < fs) begin
                                                        g.kind = KIND_FILL;
                                                        g.fill_length = fs - r_wpos;
                                                        g.new_frame = r_fpend;
                                                        n_pend = g;
                                                        n_pv = 1'b1;
                                                    end
                                                    n_wpos = '0;
                                                end
                                                n_fpend = 1'b1;
                                            end
                                            n_frame_ts = ts;
                                            if (n_await) begin
                                                n_phase = PH_DONE;
                                            end else if (32'(n_plen) <
                                                         32'(LINES_AT + LHDR_BYTES)) begin
                                                n_err = ERR_HDR_SCAN;
                                                n_phase = PH_DONE;
                                            end else begin
                                                n_phase = PH_EXT;
                                            end
                                        end else begin
                                            n_phase = PH_DONE;
                                        end
                                    end
                                end
                                PH_EXT: begin
                                    if (32'(n_bidx) == 32'(LINES_AT - 1)) begin
                                        n_phase = PH_LHDR;
                                        n_hshift = '0;
                                        n_sub = '0;
                                    end
                                end
                                PH_LHDR: begin
                                    s = {n_hshift[39:0], in_byte};
                                    n_hshift = s;
                                    n_sub = (r_sub == 3'(LHDR_BYTES - 1)) ? 3'd0 :
                                            r_sub + 3'd1;
                                    if (r_sub == 3'(LHDR_BYTES - 1) &&
                                        r_hcnt < CW'(MAX_LINE_HEADERS)) begin
                                        wr_en = 1'b1;
                                        wr_data.length = s[47:32];
                                        wr_data.row    = s[30:16];
                                        wr_data.offset = s[14:0];
                                        wr_data.cont   = s[15];
                                        n_hcnt = r_hcnt + CW'(1);
                                        if (s[15]) begin
                                            if (n_hcnt >= CW'(MAX_LINE_HEADERS) ||
                                                32'(n_plen) < 32'(n_bidx) + 32'd7) begin
                                                n_err = ERR_HDR_SCAN;
                                                n_phase = PH_DONE;
                                            end
                                        end else begin
                                            n_cursor = '0;
                                            n_next = n_bidx + LW'(1);
                                            go_lines = 1'b1;
                                        end
                                    end
                                end
                                PH_DATA: begin
                                    g.kind = KIND_DATA;
                                    g.data_byte = in_byte;
                                    g.new_frame = r_fpend;
                                    n_pend = g;
                                    n_pv = 1'b1;
                                    n_fpend = 1'b0;
                                    n_wpos = r_wpos + 28'd1;
                                    n_lrem = r_lrem - 16'd1;
                                    if (n_lrem == '0) begin
                                        n_cursor = r_cursor + CW'(1);
                                        n_next = n_bidx + LW'(1);
                                        go_lines = 1'b1;
                                    end
                                end
                                default: n_phase = n_phase;
                            endcase
                        end
                        if (32'(n_bidx) < 32'(MAX_PACKET_BYTES)) begin
                            n_bidx = n_bidx + LW'(1);
                        end
                        if (go_lines) begin
                            n_state = SQ_LINE_RD;
                        end else if (i_s_tlast) begin
                            n_state = SQ_STATUS;
                        end else if (n_pv) begin
                            n_state = SQ_FLUSH;
                        end
                    end
                end
            end
            SQ_LINE_RD: begin
                if (r_cursor >= r_hcnt) begin
                    n_phase = PH_DONE;
                    n_state = r_lastb ? SQ_STATUS : SQ_FLUSH;
                end else begin
                    rd_en = 1'b1;
                    n_state = SQ_LINE_MUL1;
                end
            end
            SQ_LINE_MUL1: n_state = SQ_LINE_MUL2;
            SQ_LINE_MUL2: n_state = SQ_LINE_EVAL;
            SQ_LINE_EVAL: begin
                rem = 16'(32'(r_plen) - 32'(r_next));
                if (32'(r_plen) < 32'(r_next) + 32'd4) begin
                    n_err = ERR_PAYLOAD;
                    n_phase = PH_DONE;
                    n_state = r_lastb ? SQ_STATUS : SQ_FLUSH;
                end else if (rd_data.length[1:0] != 2'd0) begin
                    n_err = ERR_ALIGN;
                    n_phase = PH_DONE;
                    n_state = r_lastb ? SQ_STATUS : SQ_FLUSH;
                end else if (fo > 33'(fs)) begin
                    n_err = ERR_OFFSET;
                    n_phase = PH_DONE;
                    n_state = r_lastb ? SQ_STATUS : SQ_FLUSH;
                end else begin
                    lenc = (rd_data.length > rem) ? rem : rd_data.length;
                    fill_need = fo > 33'(r_wpos);
                    if (!(fill_need && blocked)) begin
                        if (fill_need) begin
                            g.kind = KIND_FILL;
                            g.fill_length = fo[27:0] - r_wpos;
                            g.new_frame = r_fpend;
                            n_fpend = 1'b0;
                            n_pend = g;
                            n_pv = 1'b1;
                            push = r_pv;
                        end
                        n_wpos = fo[27:0];
                        if (lenc != '0) begin
                            n_lrem = lenc;
                            n_phase = PH_DATA;
                            n_state = r_lastb ? SQ_STATUS : SQ_FLUSH;
                        end else begin
                            n_cursor = r_cursor + CW'(1);
                            n_state = SQ_LINE_RD;
                        end
                    end
                end
            end
            SQ_STATUS: begin
                if (!blocked) begin
                    g.kind = KIND_STATUS;
                    g.packet_error = r_err;
                    if (r_err == ERR_OK) begin
                        if (!r_hdone) begin
                            g.packet_error = ERR_SHORT;
                        end else if (r_phase == PH_EXT || r_phase == PH_LHDR) begin
                            g.packet_error = ERR_HDR_SCAN;
                        end else if (r_phase == PH_DATA) begin
                            g.packet_error = ERR_PAYLOAD;
                        end
                    end
                    g.dropped_total  = r_drop;
                    g.received_total = r_pcnt;
                    if (r_hdone) begin
                        g.timestamp_wrapped = r_wrap;
                        g.marker_missing    = r_miss;
                        g.payload_type      = r_mtype[6:0];
                        g.first_packet      = r_first;
                    end
                    n_pend = g;
                    n_pv = 1'b1;
                    push = r_pv;
                    n_phase = PH_IDLE;
                    n_state = SQ_FLUSH;
                end
            end
            SQ_FLUSH: begin
                flush = 1'b1;
                if (!blocked) begin
                    push = r_pv;
                    n_pv = 1'b0;
                    n_state = SQ_IDLE;
                end
            end
            default: n_state = SQ_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SQ_IDLE;   r_phase <= PH_IDLE;
            r_prev_seq <= '0; r_prev_ts <= '0; r_prev_mark <= 1'b0;
            r_type_seen <= 1'b0; r_drop <= '0; r_pcnt <= '0; r_frame_ts <= '0;
            r_await <= 1'b1; r_wpos <= '0; r_bidx <= '0; r_plen <= '0;
            r_next <= '0; r_hshift <= '0; r_hcnt <= '0; r_cursor <= '0;
            r_lrem <= '0; r_sub <= '0; r_err <= ERR_OK; r_mtype <= '0;
            r_hdone <= 1'b0; r_wrap <= 1'b0; r_miss <= 1'b0; r_first <= 1'b0;
            r_fpend <= 1'b0; r_lastb <= 1'b0; r_pv <= 1'b0; r_ov <= 1'b0;
        end else begin
            r_state <= n_state;   r_phase <= n_phase;
            r_prev_seq <= n_prev_seq; r_prev_ts <= n_prev_ts;
            r_prev_mark <= n_prev_mark; r_type_seen <= n_type_seen;
            r_drop <= n_drop; r_pcnt <= n_pcnt; r_frame_ts <= n_frame_ts;
            r_await <= n_await; r_wpos <= n_wpos; r_bidx <= n_bidx;
            r_plen <= n_plen; r_next <= n_next; r_hshift <= n_hshift;
            r_hcnt <= n_hcnt; r_cursor <= n_cursor; r_lrem <= n_lrem;
            r_sub <= n_sub; r_err <= n_err; r_mtype <= n_mtype;
            r_hdone <= n_hdone; r_wrap <= n_wrap; r_miss <= n_miss;
            r_first <= n_first; r_fpend <= n_fpend; r_lastb <= n_lastb;
            r_pv <= n_pv;
            if (push) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload registers: the held result and the output beat
    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        if (push) begin
            r_out <= r_pend;
        end
    end

    logic r_out_last;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_last <= 1'b0;
        end else if (push) begin
            r_out_last <= flush;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {6'b0, r_out.first_packet, r_out.payload_type,
                         r_out.marker_missing, r_out.timestamp_wrapped,
                         r_out.received_total, r_out.dropped_total,
                         r_out.packet_error, r_out.new_frame,
                         r_out.fill_length, r_out.data_byte};

endmodule

`default_nettype wire

[sv/rvd_checker.sv]
// ----------------------------------------------------------------------------
// rvd_checker
// Port-level checks of the depacketizer output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module rvd_checker
    import rvd_pkg::*;
(
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         o_m_tvalid,
    input wire logic         i_m_tready,
    input wire logic [119:0] o_m_tdata,
    input wire logic [1:0]   o_m_tuser,
    input wire logic         o_m_tlast
);

    // status always closes the results of its byte
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == KIND_STATUS) |-> o_m_tlast)
        else $error("status beat without tlast");

    // data and fill beats carry no error code
    a_no_err_on_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != KIND_STATUS) |-> (o_m_tdata[39:37] == ERR_OK))
        else $error("error code on non-status beat");

    // fill runs are never empty
    a_fill_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == KIND_FILL) |-> (o_m_tdata[35:8] != 28'd0))
        else $error("empty fill run");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled beat changed");

endmodule

bind rtp_video_depacketizer rvd_checker u_rvd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire
